// ----- src/pcdc_pkg.sv -----
// pcdc_pkg: constants, types and functions shared by the png chunk deframer
// covers the crc-32 byte update and the known chunk type lookup
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcdc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned HDR_W   = 40;
    localparam int unsigned N_KNOWN = 16;

    localparam logic [WORD_W-1:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] FIELD_BYTES = 32'd4;

    // IHDR data offsets: width, height, then five single bytes
    localparam logic [WORD_W-1:0] IHDR_W_END = 32'd4;
    localparam logic [WORD_W-1:0] IHDR_H_END = 32'd8;
    localparam logic [WORD_W-1:0] IHDR_END   = 32'd13;

    localparam logic [WORD_W-1:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [WORD_W-1:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [WORD_W-1:0] TYPE_IEND = 32'h4945_4E44;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t KNOWN_TYPES [N_KNOWN] = '{
        TYPE_IHDR,    TYPE_IDAT,    TYPE_IEND,    32'h504C_5445,
        32'h7452_4E53, 32'h624B_4744, 32'h7445_5874, 32'h7A54_5874,
        32'h6954_5874, 32'h7449_4D45, 32'h7048_5973, 32'h6741_4D41,
        32'h6348_524D, 32'h7352_4742, 32'h6943_4350, 32'h7342_4954
    };

    // reflected crc-32 update over one byte, lsb first
    function automatic word_t crc32_byte(input word_t crc, input logic [BYTE_W-1:0] b);
        word_t c;
        c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic type_is_known(input word_t t);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < N_KNOWN; i++) begin
            if (KNOWN_TYPES[i] == t) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- src/pcdc_ifs.sv -----
// pcdc_byte_if and pcdc_chunk_if: valid/ready channels of the deframer
// depends on pcdc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pcdc_byte_if
    import pcdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface pcdc_chunk_if
    import pcdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] chunk_type;
    logic [WORD_W-1:0] chunk_length;
    logic              crc_ok;
    logic              type_known;
    logic [WORD_W-1:0] image_width;
    logic [WORD_W-1:0] image_height;
    logic [BYTE_W-1:0] bit_depth;
    logic [BYTE_W-1:0] color_type;
    logic [BYTE_W-1:0] compression_method;
    logic [BYTE_W-1:0] filter_method;
    logic [BYTE_W-1:0] interlace_method;

    modport source (
        output valid, output chunk_type, output chunk_length, output crc_ok,
        output type_known, output image_width, output image_height,
        output bit_depth, output color_type, output compression_method,
        output filter_method, output interlace_method, input ready
    );
    modport sink (
        input valid, input chunk_type, input chunk_length, input crc_ok,
        input type_known, input image_width, input image_height,
        input bit_depth, input color_type, input compression_method,
        input filter_method, input interlace_method, output ready
    );
endinterface

`default_nettype wire

// ----- src/png_chunk_deframer_crc_check.sv -----
// png_chunk_deframer_crc_check: top level of the png chunk deframer
// depends on pcdc_pkg and the channel interfaces in pcdc_ifs.sv
//
// usage:
//   bytes  : one word per stream byte after the png signature; file_start
//            flags the first byte of a new file and restarts parsing there
//   chunks : one word per finished chunk: type, length, crc match, known type,
//            and the fields of the latest IHDR
//   a byte is taken every cycle while bytes.ready is high; the chunk report is
//   loaded into the output register as the last crc byte is taken (or the
//   fourth type byte of an unknown type, after which bytes are dropped until
//   the next file start); the crc byte update is combinational
//   bytes.ready drops only while a report waits and chunks.ready is low; it
//   follows chunks.ready in the same cycle
//   reset clears the parser to the length field, the crc to all ones, the
//   IHDR fields to zero and empties the output register
`timescale 1ns / 1ps
`default_nettype none

module png_chunk_deframer_crc_check
    import pcdc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pcdc_byte_if.sink   bytes,
    pcdc_chunk_if.source chunks
);

    typedef enum logic [2:0] {
        PH_LEN  = 3'd0,
        PH_TYPE = 3'd1,
        PH_DATA = 3'd2,
        PH_CRC  = 3'd3,
        PH_HALT = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next, phase_cur;
    word_t              cnt_reg, cnt_next, cnt_cur, cnt_inc;
    word_t              len_reg, len_next;
    word_t              type_reg, type_next;
    word_t              crc_reg, crc_next, crc_cur;
    word_t              rcv_reg, rcv_next;
    word_t              width_reg, width_next;
    word_t              height_reg, height_next;
    logic [HDR_W-1:0]   hdr_reg, hdr_next;

    logic               emit, emit_ok, emit_known;
    logic               accept;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  b;

    word_t              o_type_reg, o_len_reg, o_width_reg, o_height_reg;
    logic               o_ok_reg, o_known_reg;
    logic [HDR_W-1:0]   o_hdr_reg;

    assign bytes.ready = !out_valid_reg || chunks.ready;
    assign accept      = bytes.valid && bytes.ready;
    assign b           = bytes.data_byte;

    always_comb begin
        // a file start restarts the chunk before the byte is used
        phase_cur = bytes.file_start ? PH_LEN : phase_reg;
        cnt_cur   = bytes.file_start ? '0 : cnt_reg;
        crc_cur   = bytes.file_start ? CRC_INIT : crc_reg;
        cnt_inc   = cnt_cur + 32'd1;

        phase_next  = phase_cur;
        cnt_next    = cnt_cur;
        crc_next    = crc_cur;
        len_next    = len_reg;
        type_next   = type_reg;
        rcv_next    = rcv_reg;
        width_next  = width_reg;
        height_next = height_reg;
        hdr_next    = hdr_reg;
        emit        = 1'b0;
        emit_ok     = 1'b0;
        emit_known  = 1'b0;

        case (phase_cur)
            PH_LEN: begin
                len_next = {len_reg[WORD_W-BYTE_W-1:0], b};
                cnt_next = cnt_inc;
                if (cnt_inc >= FIELD_BYTES) begin
                    cnt_next   = '0;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_next = {type_reg[WORD_W-BYTE_W-1:0], b};
                crc_next  = crc32_byte(crc_cur, b);
                cnt_next  = cnt_inc;
                if (cnt_inc >= FIELD_BYTES) begin
                    cnt_next = '0;
                    if (!type_is_known(type_next)) begin
                        phase_next = PH_HALT;
                        emit       = 1'b1;
                    end else begin
                        if (type_next == TYPE_IHDR) begin
                            width_next  = '0;
                            height_next = '0;
                            hdr_next    = '0;
                        end
                        phase_next = (len_reg == '0) ? PH_CRC : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                crc_next = crc32_byte(crc_cur, b);
                if (type_reg == TYPE_IHDR) begin
                    if (cnt_cur < IHDR_W_END) begin
                        width_next = {width_reg[WORD_W-BYTE_W-1:0], b};
                    end else if (cnt_cur < IHDR_H_END) begin
                        height_next = {height_reg[WORD_W-BYTE_W-1:0], b};
                    end else if (cnt_cur < IHDR_END) begin
                        hdr_next = {hdr_reg[HDR_W-BYTE_W-1:0], b};
                    end
                end
                cnt_next = cnt_inc;
                if (cnt_inc >= len_reg) begin
                    cnt_next   = '0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC: begin
                rcv_next = {rcv_reg[WORD_W-BYTE_W-1:0], b};
                cnt_next = cnt_inc;
                if (cnt_inc >= FIELD_BYTES) begin
                    emit       = 1'b1;
                    emit_known = 1'b1;
                    emit_ok    = ((crc_cur ^ CRC_INIT) == rcv_next);
                    phase_next = PH_LEN;
                    cnt_next   = '0;
                    crc_next   = CRC_INIT;
                end
            end
            default: begin
                // halted: drop bytes until the next file start
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg     <= PH_LEN;
            cnt_reg       <= '0;
            len_reg       <= '0;
            type_reg      <= '0;
            crc_reg       <= CRC_INIT;
            rcv_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            hdr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                len_reg    <= len_next;
                type_reg   <= type_next;
                crc_reg    <= crc_next;
                rcv_reg    <= rcv_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                hdr_reg    <= hdr_next;
            end
            if (accept && emit) begin
                out_valid_reg <= 1'b1;
            end else if (chunks.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // report payload, loaded only when a new word enters the output register
    always_ff @(posedge clk) begin
        if (accept && emit) begin
            o_type_reg   <= type_next;
            o_len_reg    <= len_next;
            o_ok_reg     <= emit_ok;
            o_known_reg  <= emit_known;
            o_width_reg  <= width_next;
            o_height_reg <= height_next;
            o_hdr_reg    <= hdr_next;
        end
    end

    assign chunks.valid              = out_valid_reg;
    assign chunks.chunk_type         = o_type_reg;
    assign chunks.chunk_length       = o_len_reg;
    assign chunks.crc_ok             = o_ok_reg;
    assign chunks.type_known         = o_known_reg;
    assign chunks.image_width        = o_width_reg;
    assign chunks.image_height       = o_height_reg;
    assign chunks.bit_depth          = o_hdr_reg[39:32];
    assign chunks.color_type         = o_hdr_reg[31:24];
    assign chunks.compression_method = o_hdr_reg[23:16];
    assign chunks.filter_method      = o_hdr_reg[15:8];
    assign chunks.interlace_method   = o_hdr_reg[7:0];

endmodule

`default_nettype wire

// ----- src/pcdc_checker.sv -----
// pcdc_checker: port-level assertions for the png chunk deframer
// bound to png_chunk_deframer_crc_check; depends on pcdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcdc_checker
    import pcdc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [WORD_W-1:0] out_type,
    input wire logic              out_crc_ok,
    input wire logic              out_known
);

    // a stalled report word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_type))
        else $error("report word dropped or changed under stall");

    // bytes are held off only while a report waits
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("byte side stalled without a pending report");

    // unknown type reports never claim a crc match
    a_unknown_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_known |-> !out_crc_ok)
        else $error("crc_ok set on unknown type");

    // a fresh report needs a byte taken in the cycle before
    a_report_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
        else $error("report without an accepted byte");

endmodule

bind png_chunk_deframer_crc_check pcdc_checker u_pcdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (bytes.valid),
    .in_ready   (bytes.ready),
    .out_valid  (chunks.valid),
    .out_ready  (chunks.ready),
    .out_type   (chunks.chunk_type),
    .out_crc_ok (chunks.crc_ok),
    .out_known  (chunks.type_known)
);

`default_nettype wire

// ----- sim/png_chunk_deframer_crc_check_tb.sv -----
// png_chunk_deframer_crc_check_tb: self-checking bench for the png chunk deframer
// predicts each chunk report from the byte stream and checks it word by word
// depends on pcdc_pkg, pcdc_ifs.sv and png_chunk_deframer_crc_check
`timescale 1ns / 1ps

module png_chunk_deframer_crc_check_tb;
    import pcdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [31:0] CRC_SEED    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_REFL    = 32'hEDB8_8320;
    localparam logic [31:0] CT_IHDR     = "IHDR";

    typedef enum logic [2:0] {
        ST_LENGTH = 3'd0,
        ST_TYPE   = 3'd1,
        ST_DATA   = 3'd2,
        ST_CRC    = 3'd3,
        ST_HALT   = 3'd4
    } parse_phase_t;

    typedef struct packed {
        logic        file_start;
        logic [7:0]  data_byte;
    } stream_word_t;

    typedef struct packed {
        logic [31:0] chunk_type;
        logic [31:0] chunk_length;
        logic        crc_ok;
        logic        type_known;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  bit_depth;
        logic [7:0]  color_type;
        logic [7:0]  compression_method;
        logic [7:0]  filter_method;
        logic [7:0]  interlace_method;
    } chunk_report_t;

    logic clk;
    logic rst_n;

    pcdc_byte_if  byte_ch ();
    pcdc_chunk_if chunk_ch ();

    png_chunk_deframer_crc_check u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .chunks (chunk_ch)
    );

    stream_word_t  stream_pending [$];
    chunk_report_t reports_due [$];
    logic [7:0]    chunk_body [$];
    stream_word_t  next_word;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatch_count;
    int unsigned cycle_count;
    int unsigned bytes_queued;
    int unsigned chunks_queued;
    logic        stream_clean;

    // deframer shadow state
    parse_phase_t sh_phase;
    logic [31:0]  sh_count;
    logic [31:0]  sh_length;
    logic [31:0]  sh_type;
    logic [31:0]  sh_crc;
    logic [31:0]  sh_rx_crc;
    logic [31:0]  sh_width;
    logic [31:0]  sh_height;
    logic [39:0]  sh_hdr;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // reflected crc-32, one input bit at a time
    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_REFL;
        end
        return r;
    endfunction

    function automatic logic [31:0] known_type_at(input int idx);
        case (idx)
            0:       return "IHDR";
            1:       return "IDAT";
            2:       return "IEND";
            3:       return "PLTE";
            4:       return "tRNS";
            5:       return "bKGD";
            6:       return "tEXt";
            7:       return "zTXt";
            8:       return "iTXt";
            9:       return "tIME";
            10:      return "pHYs";
            11:      return "gAMA";
            12:      return "cHRM";
            13:      return "sRGB";
            14:      return "iCCP";
            default: return "sBIT";
        endcase
    endfunction

    function automatic logic is_known_type(input logic [31:0] t);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 16; i++)
            if (known_type_at(i) == t)
                hit = 1'b1;
        return hit;
    endfunction

    task automatic queue_report(input logic ok, input logic known);
        chunk_report_t r;
        r.chunk_type         = sh_type;
        r.chunk_length       = sh_length;
        r.crc_ok             = ok;
        r.type_known         = known;
        r.image_width        = sh_width;
        r.image_height       = sh_height;
        r.bit_depth          = sh_hdr[39:32];
        r.color_type         = sh_hdr[31:24];
        r.compression_method = sh_hdr[23:16];
        r.filter_method      = sh_hdr[15:8];
        r.interlace_method   = sh_hdr[7:0];
        reports_due.push_back(r);
    endtask

    task automatic restart_chunk();
        sh_phase = ST_LENGTH;
        sh_count = '0;
        sh_crc   = CRC_SEED;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic fs);
        if (fs)
            restart_chunk();
        case (sh_phase)
            ST_LENGTH: begin
                sh_length = {sh_length[23:0], b};
                sh_count  = sh_count + 1;
                if (sh_count >= 4)
                begin
                    sh_count = '0;
                    sh_phase = ST_TYPE;
                end
            end
            ST_TYPE: begin
                sh_type  = {sh_type[23:0], b};
                sh_crc   = crc32_step(sh_crc, b);
                sh_count = sh_count + 1;
                if (sh_count >= 4)
                begin
                    sh_count = '0;
                    if (!is_known_type(sh_type))
                    begin
                        sh_phase = ST_HALT;
                        queue_report(1'b0, 1'b0);
                    end
                    else
                    begin
                        if (sh_type == CT_IHDR)
                        begin
                            sh_width  = '0;
                            sh_height = '0;
                            sh_hdr    = '0;
                        end
                        sh_phase = (sh_length == 0) ? ST_CRC : ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                sh_crc = crc32_step(sh_crc, b);
                if (sh_type == CT_IHDR)
                begin
                    if (sh_count < 4)
                        sh_width = {sh_width[23:0], b};
                    else if (sh_count < 8)
                        sh_height = {sh_height[23:0], b};
                    else if (sh_count < 13)
                        sh_hdr = {sh_hdr[31:0], b};
                end
                sh_count = sh_count + 1;
                if (sh_count >= sh_length)
                begin
                    sh_count = '0;
                    sh_phase = ST_CRC;
                end
            end
            ST_CRC: begin
                sh_rx_crc = {sh_rx_crc[23:0], b};
                sh_count  = sh_count + 1;
                if (sh_count >= 4)
                begin
                    queue_report((sh_crc ^ CRC_SEED) == sh_rx_crc, 1'b1);
                    restart_chunk();
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_report();
        chunk_report_t e;
        if (reports_due.size() == 0)
        begin
            $display("%0t: unexpected chunk report: expected none, actual type %h",
                     $time, chunk_ch.chunk_type);
            mismatch_count++;
        end
        else
        begin
            e = reports_due.pop_front();
            check_field("chunk_type", chunk_ch.chunk_type, e.chunk_type);
            check_field("chunk_length", chunk_ch.chunk_length, e.chunk_length);
            check_field("crc_ok", chunk_ch.crc_ok, e.crc_ok);
            check_field("type_known", chunk_ch.type_known, e.type_known);
            check_field("image_width", chunk_ch.image_width, e.image_width);
            check_field("image_height", chunk_ch.image_height, e.image_height);
            check_field("bit_depth", chunk_ch.bit_depth, e.bit_depth);
            check_field("color_type", chunk_ch.color_type, e.color_type);
            check_field("compression_method", chunk_ch.compression_method,
                        e.compression_method);
            check_field("filter_method", chunk_ch.filter_method, e.filter_method);
            check_field("interlace_method", chunk_ch.interlace_method, e.interlace_method);
        end
    endtask

    // byte driver: the shadow model advances on every accepted word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid      <= 1'b0;
            byte_ch.data_byte  <= '0;
            byte_ch.file_start <= 1'b0;
            restart_chunk();
            sh_length = '0;
            sh_type   = '0;
            sh_rx_crc = '0;
            sh_width  = '0;
            sh_height = '0;
            sh_hdr    = '0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                deframe_byte(byte_ch.data_byte, byte_ch.file_start);
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (stream_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = stream_pending.pop_front();
                    byte_ch.valid      <= 1'b1;
                    byte_ch.data_byte  <= next_word.data_byte;
                    byte_ch.file_start <= next_word.file_start;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // report monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_ch.ready <= 1'b0;
        end
        else
        begin
            if (chunk_ch.valid && chunk_ch.ready)
                check_report();
            chunk_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, reports_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [7:0] rand_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 8'h00;
        else if (roll < 16)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic fs);
        stream_word_t w;
        w.data_byte  = b;
        w.file_start = fs;
        stream_pending.push_back(w);
        bytes_queued++;
    endtask

    task automatic body_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            chunk_body.push_back(w[8*i +: 8]);
    endtask

    task automatic fill_body(input int n);
        chunk_body.delete();
        for (int i = 0; i < n; i++)
            chunk_body.push_back(rand_byte());
    endtask

    // length, type, chunk_body, crc; cut < 0 sends the whole chunk,
    // otherwise only the first cut bytes go out
    task automatic put_chunk(input logic [31:0] ctype, input logic [31:0] len_field,
                             input logic fs, input logic bad_crc, input int cut);
        logic [7:0]  raw [$];
        logic [31:0] c;
        int          n;
        c = CRC_SEED;
        for (int i = 3; i >= 0; i--)
            raw.push_back(len_field[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
        begin
            raw.push_back(ctype[8*i +: 8]);
            c = crc32_step(c, ctype[8*i +: 8]);
        end
        foreach (chunk_body[i])
        begin
            raw.push_back(chunk_body[i]);
            c = crc32_step(c, chunk_body[i]);
        end
        c = c ^ CRC_SEED;
        if (bad_crc)
            c = c ^ (32'd1 << $urandom_range(31));
        for (int i = 3; i >= 0; i--)
            raw.push_back(c[8*i +: 8]);
        n = (cut < 0 || cut > raw.size()) ? raw.size() : cut;
        for (int i = 0; i < n; i++)
            put_byte(raw[i], fs && i == 0);
        if (n == raw.size())
            chunks_queued++;
    endtask

    task automatic directed_stimulus();
        // extreme IHDR fields, no file start after reset
        chunk_body.delete();
        body_word(32'hFFFF_FFFF);
        body_word(32'h0000_0000);
        chunk_body.push_back(8'hFF);
        chunk_body.push_back(8'h00);
        chunk_body.push_back(8'hFF);
        chunk_body.push_back(8'h00);
        chunk_body.push_back(8'hFF);
        put_chunk("IHDR", 13, 1'b0, 1'b0, -1);
        chunk_body.delete();
        put_chunk("IDAT", 0, 1'b0, 1'b0, -1);
        fill_body(3);
        put_chunk("tEXt", 3, 1'b0, 1'b1, -1);
        chunk_body.delete();
        put_chunk("IEND", 0, 1'b0, 1'b0, -1);
        // short IHDR, then one longer than 13 bytes
        fill_body(6);
        put_chunk("IHDR", 6, 1'b1, 1'b0, -1);
        fill_body(16);
        put_chunk("IHDR", 16, 1'b0, 1'b0, -1);
        // all-ones length abandoned by a new file
        fill_body(2);
        put_chunk("IDAT", 32'hFFFF_FFFF, 1'b0, 1'b0, 10);
        chunk_body.delete();
        // file start mid type field
        put_chunk("IEND", 0, 1'b1, 1'b0, 6);
        put_chunk("IEND", 0, 1'b1, 1'b0, -1);
        // unknown type halts; trailing words are dropped
        put_chunk("abcd", 0, 1'b0, 1'b0, -1);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        // file start mid crc field
        fill_body(1);
        put_chunk("PLTE", 1, 1'b1, 1'b0, 11);
        chunk_body.delete();
        put_chunk("IEND", 0, 1'b1, 1'b0, -1);
        stream_clean = 1'b1;
    endtask

    task automatic gen_file();
        int          n;
        int          roll;
        int          len;
        logic        fs;
        logic [31:0] t;
        fs = !stream_clean || ($urandom_range(99) < 85);
        stream_clean = 1'b1;
        roll = $urandom_range(99);
        len = (roll < 15) ? $urandom_range(12) : (roll < 25) ? $urandom_range(20, 14) : 13;
        fill_body(len);
        put_chunk("IHDR", len, fs, $urandom_range(99) < 10, -1);
        n = $urandom_range(5);
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
            begin
                // unknown type: random, or one bit off a known one
                t = ($urandom_range(1) != 0) ? $urandom()
                    : known_type_at($urandom_range(15)) ^ (32'd1 << $urandom_range(31));
                fill_body($urandom_range(4));
                put_chunk(t, chunk_body.size(), 1'b0, 1'b0, -1);
                repeat ($urandom_range(4))
                    put_byte(rand_byte(), 1'b0);
                stream_clean = 1'b0;
                return;
            end
            if (roll < 10)
            begin
                fill_body($urandom_range(8));
                len = ($urandom_range(3) == 0) ? $urandom() : chunk_body.size();
                put_chunk(known_type_at($urandom_range(15)), len, 1'b0, 1'b0,
                          $urandom_range(chunk_body.size() + 11));
                stream_clean = 1'b0;
                return;
            end
            len = ($urandom_range(99) < 75) ? $urandom_range(12) : $urandom_range(40, 13);
            fill_body(len);
            put_chunk(known_type_at($urandom_range(15)), len,
                      $urandom_range(99) < 4, $urandom_range(99) < 12, -1);
        end
        if ($urandom_range(99) < 80)
        begin
            chunk_body.delete();
            put_chunk("IEND", 0, 1'b0, 1'b0, -1);
        end
    endtask

    task automatic random_stimulus(input int unsigned min_bytes, input int unsigned min_chunks);
        int unsigned b0;
        int unsigned c0;
        b0 = bytes_queued;
        c0 = chunks_queued;
        while (bytes_queued - b0 < min_bytes || chunks_queued - c0 < min_chunks)
            gen_file();
    endtask

    initial begin
        int phase;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        bytes_queued   = 0;
        chunks_queued  = 0;
        stream_clean   = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (phase == 0)
                directed_stimulus();
            random_stimulus(100, 3);
            while (stream_pending.size() != 0 || byte_ch.valid || reports_due.size() != 0)
                @(negedge clk);
        end
        // let any stray report surface
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && reports_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
